// ===== sv/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  localparam logic [1:0] STATUS_READY = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_BUSY  = 2'd2;

  localparam logic [1:0] START_NONE     = 2'd0;
  localparam logic [1:0] START_COND     = 2'd1;
  localparam logic [1:0] START_REPEATED = 2'd2;

  localparam logic [7:0] ADDR_MASK = 8'hFE;
  localparam logic [7:0] READ_BIT  = 8'h01;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic [7:0] address_byte;
    logic       is_read;
    logic [7:0] length;
    logic       repeated_start;
    logic       hold_bus;
    logic       arbitration_lost;
    logic       nack_received;
    logic [7:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] start_kind;
    logic       stop_now;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       transmit_mode;
    logic       nack_next;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [3:0] rx_index;
  } res_t;

endpackage

// ===== sv/i2cm_txbuf.sv =====
// ----------------------------------------------------------------------------
// i2cm_txbuf
// Transmit byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2cm_txbuf #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  logic [7:0]                      wr_data,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output logic [7:0]                      rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on an address collision
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Transfer state and per-word update; reads the buffer one word ahead.
// ----------------------------------------------------------------------------
module i2cm_seq #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  i2cm_pkg::cmd_t                  cmd,
  input  logic [7:0]                      buf_rd_data,
  output logic                            buf_wr_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] buf_wr_addr,
  output logic [7:0]                      buf_wr_data,
  output logic [$clog2(BUFFER_DEPTH)-1:0] buf_rd_addr,
  output i2cm_pkg::res_t                  res
);

  import i2cm_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [8:0]    LEN_MAX = 9'(BUFFER_DEPTH);
  localparam logic [CW-1:0] PTR_MAX = CW'(BUFFER_DEPTH);

  localparam logic [2:0] PH_READY  = 3'd0;
  localparam logic [2:0] PH_ERROR  = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_SENT   = 3'd4;

  logic [2:0]    phase, phase_next;
  logic          master, master_next;
  logic          txdir, txdir_next;
  logic          dir_write, dir_write_next;
  logic          no_ack, no_ack_next;
  logic          hold, hold_next;
  logic [CW-1:0] xfer_len, xfer_len_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] load_ptr, load_ptr_next;

  logic          busy;
  logic [8:0]    len_ext;
  logic [CW-1:0] cnt_inc;
  logic [CW+3:0] cnt_ext;

  assign busy    = (phase == PH_HEADER) || (phase == PH_DATA) || (phase == PH_SENT);
  assign len_ext = {1'b0, cmd.length};
  assign cnt_inc = cnt + 1'b1;
  assign cnt_ext = {4'b0, cnt};

  always_comb begin
    phase_next     = phase;
    master_next    = master;
    txdir_next     = txdir;
    dir_write_next = dir_write;
    no_ack_next    = no_ack;
    hold_next      = hold;
    xfer_len_next  = xfer_len;
    cnt_next       = cnt;
    load_ptr_next  = load_ptr;
    buf_wr_en      = 1'b0;
    res            = '0;

    if (accept) begin
      case (cmd.command)
        CMD_LOAD: begin
          if (!busy && (load_ptr < PTR_MAX)) begin
            buf_wr_en     = 1'b1;
            load_ptr_next = load_ptr + 1'b1;
          end
        end
        CMD_START: begin
          if (!busy) begin
            load_ptr_next = '0;
            if ((cmd.length == 8'd0) || (len_ext > LEN_MAX)) begin
              phase_next = PH_ERROR;
            end else begin
              xfer_len_next  = len_ext[CW-1:0];
              cnt_next       = '0;
              phase_next     = PH_HEADER;
              dir_write_next = !cmd.is_read;
              hold_next      = cmd.hold_bus;
              txdir_next     = 1'b1;
              master_next    = 1'b1;
              res.send_valid = 1'b1;
              if (cmd.is_read) begin
                res.send_byte  = (cmd.address_byte & ADDR_MASK) | READ_BIT;
                no_ack_next    = 1'b0;
                res.start_kind = cmd.repeated_start ? START_REPEATED : START_COND;
              end else begin
                res.send_byte  = cmd.address_byte & ADDR_MASK;
                res.start_kind = START_COND;
              end
            end
          end
        end
        CMD_EVENT: begin
          if (cmd.arbitration_lost) begin
            master_next  = 1'b0;
            res.stop_now = 1'b1;
            phase_next   = PH_ERROR;
          end else if (master) begin
            if (cmd.nack_received && txdir) begin
              master_next  = 1'b0;
              res.stop_now = 1'b1;
              phase_next   = PH_ERROR;
            end else begin
              if (phase == PH_HEADER) begin
                txdir_next = dir_write;
                phase_next = PH_DATA;
              end
              if (phase_next == PH_DATA) begin
                cnt_next = cnt_inc;
                if (xfer_len <= cnt_inc) begin
                  phase_next = PH_SENT;
                end
                if (txdir_next) begin
                  res.send_valid = 1'b1;
                  res.send_byte  = buf_rd_data;
                end else begin
                  if (cnt_inc == xfer_len) begin
                    no_ack_next = 1'b1;
                  end
                  res.rx_valid = 1'b1;
                  res.rx_data  = cmd.rx_byte;
                  res.rx_index = cnt_ext[3:0];
                end
              end else if (phase == PH_SENT) begin
                phase_next = PH_READY;
                txdir_next = 1'b0;
                if (!hold) begin
                  master_next  = 1'b0;
                  res.stop_now = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    case (phase_next)
      PH_READY: res.status = STATUS_READY;
      PH_ERROR: res.status = STATUS_ERROR;
      default:  res.status = STATUS_BUSY;
    endcase
    res.transmit_mode = txdir_next;
    res.nack_next     = no_ack_next;
  end

  assign buf_wr_addr = load_ptr[AW-1:0];
  assign buf_wr_data = cmd.tx_byte;
  assign buf_rd_addr = cnt_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_READY;
      master    <= 1'b0;
      txdir     <= 1'b0;
      dir_write <= 1'b0;
      no_ack    <= 1'b0;
      hold      <= 1'b0;
      xfer_len  <= CW'(1);
      cnt       <= '0;
      load_ptr  <= '0;
    end else begin
      phase     <= phase_next;
      master    <= master_next;
      txdir     <= txdir_next;
      dir_write <= dir_write_next;
      no_ack    <= no_ack_next;
      hold      <= hold_next;
      xfer_len  <= xfer_len_next;
      cnt       <= cnt_next;
      load_ptr  <= load_ptr_next;
    end
  end

endmodule

// ===== sv/i2cm_outq.sv =====
// ----------------------------------------------------------------------------
// i2cm_outq
// Result output register with one skid entry.
// ----------------------------------------------------------------------------
module i2cm_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  i2cm_pkg::res_t push_word,
  output logic           full,
  output logic           res_valid,
  input  logic           res_stall,
  output i2cm_pkg::res_t res_word
);

  import i2cm_pkg::*;

  logic skid_valid;
  res_t skid_word;
  logic take;

  assign take = res_valid && !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!res_valid || take) begin
        res_word <= push_word;
      end else begin
        skid_word <= push_word;
      end
    end else if (take && skid_valid) begin
      res_word <= skid_word;
    end
  end

endmodule

// ===== sv/i2c_master_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Each result word is registered from its command word, into the output register or the skid entry.
// Throughput: 1 word per cycle while cmd_stall is low; the buffer is read one word ahead.
// cmd_stall rises only when both output and skid entries are full.
// Reset: synchronous, clears transfer state and output; buffer is not cleared.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = i2cm_pkg::BUFFER_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  i2cm_pkg::cmd_t cmd_word,
  output logic           res_valid,
  input  logic           res_stall,
  output i2cm_pkg::res_t res_word
);

  import i2cm_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          accept;
  logic          buf_wr_en;
  logic [AW-1:0] buf_wr_addr;
  logic [7:0]    buf_wr_data;
  logic [AW-1:0] buf_rd_addr;
  logic [7:0]    buf_rd_data;
  res_t          seq_res;

  assign accept = cmd_valid && !cmd_stall;

  i2cm_txbuf #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_txbuf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (buf_wr_addr),
    .wr_data (buf_wr_data),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  i2cm_seq #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd_word),
    .buf_rd_data (buf_rd_data),
    .buf_wr_en   (buf_wr_en),
    .buf_wr_addr (buf_wr_addr),
    .buf_wr_data (buf_wr_data),
    .buf_rd_addr (buf_rd_addr),
    .res         (seq_res)
  );

  i2cm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (seq_res),
    .full      (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

// ===== sv/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input i2cm_pkg::res_t res_word
);

  import i2cm_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_word))
    else $error("stalled result word changed");

  a_start_sends: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_word.start_kind != START_NONE) |->
      res_word.send_valid && res_word.transmit_mode && (res_word.status == STATUS_BUSY))
    else $error("start without address send");

  a_stop_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.stop_now |-> (res_word.status != STATUS_BUSY))
    else $error("stop while busy");

  a_rx_dir: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.rx_valid |-> !res_word.transmit_mode && !res_word.send_valid)
    else $error("receive reported in transmit mode");

endmodule

bind i2c_master_transfer_sequencer i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

// ===== tb/tb_i2c_master_transfer_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer
// Self-checking bench for the I2C master transfer sequencer. A scoreboard
// class predicts the result word of every accepted command word; plain tasks
// drive buffer loads, write and read transfers, bus events, aborts and noise
// with random gaps and output stalls, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
  import i2cm_pkg::*;

  localparam int DEPTH = BUFFER_DEPTH_DEF;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int ITEM_TARGET = 1000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_FAULT, SEQ_ADDR, SEQ_DATA, SEQ_DONE
  } seq_phase_e;

  class i2c_xfer_scoreboard;
    seq_phase_e seq;
    bit         bus_owner;
    bit         tx_dir;
    bit         dir_write;
    bit         no_ack;
    bit         hold;
    logic [4:0] xfer_len;
    logic [4:0] byte_cnt;
    logic [4:0] load_ptr;
    logic [7:0] tx_buf [DEPTH];
    bit         written [DEPTH];
    res_t       pending_results [$];
    int         checked, mismatches;
    int         loads, starts, events, bytes_sent, rx_reported, faults;

    function new();
      seq = SEQ_IDLE;
      bus_owner = 0;
      tx_dir = 0;
      dir_write = 0;
      no_ack = 0;
      hold = 0;
      xfer_len = 5'd1;
      byte_cnt = '0;
      load_ptr = '0;
      foreach (written[i]) begin
        written[i] = 0;
        tx_buf[i] = 8'h00;
      end
    endfunction

    function bit is_active();
      return seq >= SEQ_ADDR;
    endfunction

    // entries 0..n-1 all loaded since reset
    function int loaded_prefix();
      int n;
      n = 0;
      while (n < DEPTH && written[n]) n++;
      return n;
    endfunction

    function void note_command(cmd_t c);
      res_t r;
      bit   moved;
      r = '0;
      moved = 0;
      case (c.command)
        CMD_LOAD: begin
          if (!is_active() && load_ptr < DEPTH) begin
            tx_buf[load_ptr] = c.tx_byte;
            written[load_ptr] = 1;
            load_ptr++;
            loads++;
          end
        end
        CMD_START: begin
          if (!is_active()) begin
            load_ptr = '0;
            if (c.length == 8'd0 || c.length > DEPTH) begin
              seq = SEQ_FAULT;
              faults++;
            end else begin
              xfer_len = c.length[4:0];
              byte_cnt = '0;
              seq = SEQ_ADDR;
              dir_write = !c.is_read;
              hold = c.hold_bus;
              tx_dir = 1;
              bus_owner = 1;
              starts++;
              r.send_valid = 1'b1;
              if (c.is_read) begin
                r.send_byte = (c.address_byte & ADDR_MASK) | READ_BIT;
                no_ack = 0;
                r.start_kind = c.repeated_start ? START_REPEATED : START_COND;
              end else begin
                r.send_byte = c.address_byte & ADDR_MASK;
                r.start_kind = START_COND;
              end
            end
          end
        end
        CMD_EVENT: begin
          events++;
          if (c.arbitration_lost) begin
            bus_owner = 0;
            r.stop_now = 1'b1;
            seq = SEQ_FAULT;
            faults++;
          end else if (bus_owner) begin
            if (c.nack_received && tx_dir) begin
              bus_owner = 0;
              r.stop_now = 1'b1;
              seq = SEQ_FAULT;
              faults++;
            end else begin
              // address done: switch to data direction
              if (seq == SEQ_ADDR) begin
                tx_dir = dir_write;
                seq = SEQ_DATA;
              end
              if (seq == SEQ_DATA) begin
                moved = 1;
                if (tx_dir) begin
                  r.send_valid = 1'b1;
                  r.send_byte = (byte_cnt < DEPTH) ? tx_buf[byte_cnt] : 8'h00;
                  bytes_sent++;
                end else begin
                  if (xfer_len == 1 || byte_cnt + 1 == xfer_len) no_ack = 1;
                  r.rx_valid = 1'b1;
                  r.rx_data = c.rx_byte;
                  r.rx_index = byte_cnt[3:0];
                  rx_reported++;
                end
                byte_cnt++;
                if (xfer_len <= byte_cnt) seq = SEQ_DONE;
              end
              if (!moved && seq == SEQ_DONE) begin
                seq = SEQ_IDLE;
                tx_dir = 0;
                if (!hold) begin
                  bus_owner = 0;
                  r.stop_now = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
      case (seq)
        SEQ_IDLE:  r.status = STATUS_READY;
        SEQ_FAULT: r.status = STATUS_ERROR;
        default:   r.status = STATUS_BUSY;
      endcase
      r.transmit_mode = tx_dir;
      r.nack_next = no_ack;
      pending_results.push_back(r);
    endfunction

    function string field_diff(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) return $sformatf(" %s exp=%0h got=%0h", name, want, got);
      return "";
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string diffs;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d (%0h) arrived with no command pending", checked, got);
        return;
      end
      want = pending_results.pop_front();
      diffs = {field_diff("status", 8'(want.status), 8'(got.status)),
               field_diff("start_kind", 8'(want.start_kind), 8'(got.start_kind)),
               field_diff("stop_now", 8'(want.stop_now), 8'(got.stop_now)),
               field_diff("send_valid", 8'(want.send_valid), 8'(got.send_valid)),
               field_diff("send_byte", want.send_byte, got.send_byte),
               field_diff("transmit_mode", 8'(want.transmit_mode),
                          8'(got.transmit_mode)),
               field_diff("nack_next", 8'(want.nack_next), 8'(got.nack_next)),
               field_diff("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid)),
               field_diff("rx_data", want.rx_data, got.rx_data),
               field_diff("rx_index", 8'(want.rx_index), 8'(got.rx_index))};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= 10) $display("result word %0d mismatch:%s", checked, diffs);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd_word;
  logic res_valid;
  logic res_stall;
  res_t res_word;

  i2c_xfer_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int          input_stalls = 0;
  int          items_sent;
  bit          quiet_sender;

  i2c_master_transfer_sequencer #(
    .BUFFER_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_word (cmd_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word (res_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) sb.check_result(res_word);
      if (cmd_valid && !cmd_stall) sb.note_command(cmd_word);
      if (cmd_valid && cmd_stall) input_stalls++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic cmd_t rand_word();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(cmd_t)-1:0];
  endfunction

  function automatic cmd_t load_word(logic [7:0] b);
    cmd_t w;
    w = rand_word();
    w.command = CMD_LOAD;
    w.tx_byte = b;
    return w;
  endfunction

  function automatic cmd_t start_word(logic [7:0] addr, logic rd, logic [7:0] len,
                                      logic rs, logic hb);
    cmd_t w;
    w = rand_word();
    w.command = CMD_START;
    w.address_byte = addr;
    w.is_read = rd;
    w.length = len;
    w.repeated_start = rs;
    w.hold_bus = hb;
    return w;
  endfunction

  function automatic cmd_t event_word(logic arbl, logic nack, logic [7:0] rxb);
    cmd_t w;
    w = rand_word();
    w.command = CMD_EVENT;
    w.arbitration_lost = arbl;
    w.nack_received = nack;
    w.rx_byte = rxb;
    return w;
  endfunction

  // a write start must never reach a buffer entry that was never loaded
  function automatic cmd_t fix_word(cmd_t w);
    int avail;
    avail = sb.loaded_prefix();
    if (w.command == CMD_START && !sb.is_active() && !w.is_read &&
        w.length != 8'd0 && w.length <= DEPTH && w.length > avail) begin
      if (avail > 0) w.length = 8'(avail);
      else w.is_read = 1'b1;
    end
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(cmd_t w);
    int gap;
    gap = quiet_sender ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= fix_word(w);
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic run_transfer();
    logic       rd;
    logic [7:0] len;
    int         r, n_loads, n_events;
    rd = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 55) len = 8'($urandom_range(1, 3));
    else if (r < 92) len = 8'($urandom_range(1, DEPTH));
    else if (r < 96) len = 8'd0;
    else len = 8'($urandom_range(DEPTH + 1, 255));
    if (rd) n_loads = $urandom_range(0, 2);
    else if (len >= 1 && len <= DEPTH) n_loads = int'(len);
    else n_loads = $urandom_range(0, 3);
    if ($urandom_range(0, 15) == 0) n_loads = DEPTH + 1;
    quiet_sender = ($urandom_range(0, 4) == 0);
    repeat (n_loads) begin
      send_word(load_word(8'($urandom_range(0, 255))));
      items_sent++;
    end
    send_word(start_word(8'($urandom_range(0, 255)), rd, len, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))));
    items_sent++;
    // address byte, data bytes, then the closing event
    n_events = (len >= 1 && len <= DEPTH) ? int'(len) + 2 : $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) n_events = $urandom_range(0, n_events + 2);
    repeat (n_events) begin
      send_word(event_word($urandom_range(0, 49) == 0,
                           sb.tx_dir ? ($urandom_range(0, 29) == 0)
                                     : 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255))));
      items_sent++;
    end
  endtask

  // output side: random stalls, quiet stretches, one long hold-off
  initial begin
    int hold_left;
    int run_left;
    bit long_done;
    res_stall = 1'b0;
    hold_left = 0;
    run_left = 0;
    long_done = 0;
    forever begin
      @(negedge clk);
      if (!long_done && sb.checked >= 300) begin
        long_done = 1;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        res_stall <= 1'b0;
        run_left--;
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          run_left = $urandom_range(20, 80);
        end else begin
          hold_left = pick_gap();
          run_left = $urandom_range(0, 4);
        end
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped at cycle limit %0d", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    cmd_t w;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_word = '0;
    quiet_sender = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle event, no-op, loads, write, read with hold, aborts
    send_word(event_word(1'b0, 1'b0, 8'h5A));
    w = rand_word();
    w.command = CMD_NOP;
    send_word(w);
    send_word(load_word(8'h00));
    send_word(load_word(8'hFF));
    send_word(load_word(8'hA5));
    send_word(start_word(8'hFF, 1'b0, 8'd3, 1'b1, 1'b0));
    repeat (4) send_word(event_word(1'b0, 1'b0, 8'h3C));
    send_word(start_word(8'h00, 1'b1, 8'd2, 1'b1, 1'b1));
    send_word(event_word(1'b0, 1'b0, 8'h00));
    send_word(event_word(1'b0, 1'b1, 8'hFF));
    send_word(event_word(1'b0, 1'b0, 8'h81));
    send_word(start_word(8'h7E, 1'b1, 8'd1, 1'b0, 1'b0));
    send_word(load_word(8'h99));
    send_word(start_word(8'h42, 1'b0, 8'd1, 1'b0, 1'b0));
    send_word(event_word(1'b1, 1'b0, 8'h12));
    send_word(start_word(8'h10, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(start_word(8'h10, 1'b1, 8'd17, 1'b0, 1'b0));
    send_word(start_word(8'hC3, 1'b0, 8'd1, 1'b0, 1'b0));
    send_word(event_word(1'b0, 1'b1, 8'h00));
    send_word(event_word(1'b1, 1'b1, 8'hFF));

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        w = rand_word();
        w.command = 2'($urandom_range(0, 3));
        send_word(w);
      end else begin
        run_transfer();
      end
    end
    quiet_sender = 0;
    cmd_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d loads, %0d transfer starts, %0d bus events, %0d error ends",
             sb.loads, sb.starts, sb.events, sb.faults);
    $display("Checked %0d result words (%0d bytes sent, %0d received), %0d input stalls",
             sb.checked, sb.bytes_sent, sb.rx_reported, input_stalls);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/i2cm_pkg.sv
sv/i2cm_txbuf.sv
sv/i2cm_seq.sv
sv/i2cm_outq.sv
sv/i2c_master_transfer_sequencer.sv
sv/i2cm_checker.sv
tb/tb_i2c_master_transfer_sequencer.sv
